>>> rtl/tmhq_pkg.sv
// Shared constants, types and status codes for the timer queue.
package tmhq_pkg;
    localparam int QueueDepth = 64;
    localparam int AddrBits   = $clog2(QueueDepth);
    localparam int CountBits  = $clog2(QueueDepth + 1);
    localparam int IdBits     = 16;
    localparam int TimeBits   = 63;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_MISS      = 3'd3;
    localparam logic [2:0] ST_POPPED    = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    typedef struct packed {
        logic [TimeBits-1:0] expiry;
        logic [IdBits-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic                we;
        logic [AddrBits-1:0] waddr;
        t_entry              wdata;
        logic [AddrBits-1:0] raddr;
    } t_store_ctl;
endpackage

>>> rtl/timer_min_heap_queue.sv
// Top level of the timer queue: request sequencer, result register and storage.
// Usage: a request word enters on i_valid while o_stall is low. It adds a timer,
// cancels the first pending timer with a given id, or pops the earliest timer
// when its expiry is at or before i_now_time. Each request yields one result
// word on o_valid, held until a cycle with i_stall low takes it.
// Timers live in a memory kept sorted by expiry, earlier adds first among equals.
// One shared compare step reads one entry at a time from the single read port.
// An add moves every later entry up by one; a rejected add only reads the head.
// A cancel scans to the match and closes the gap; a miss scans the whole queue.
// A pop closes the gap from the head, or leaves the queue as is when nothing is due.
// o_stall is high from acceptance until the result word is taken, so one
// request is in flight at a time; a stalled receiver holds the whole block.
// Synchronous reset empties the queue; memory contents need no clearing.
module timer_min_heap_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_task_id,
    input  logic [62:0] i_expire_time,
    input  logic [62:0] i_now_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_task_id,
    output logic        o_next_valid,
    output logic [62:0] o_next_expiry,
    output logic [6:0]  o_entry_count
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_A_RD  = 4'd1;
    localparam logic [3:0] S_A_CMP = 4'd2;
    localparam logic [3:0] S_C_RD  = 4'd3;
    localparam logic [3:0] S_C_CMP = 4'd4;
    localparam logic [3:0] S_S_RD  = 4'd5;
    localparam logic [3:0] S_S_CMP = 4'd6;
    localparam logic [3:0] S_P_RD  = 4'd7;
    localparam logic [3:0] S_P_CMP = 4'd8;
    localparam logic [3:0] S_H_RD  = 4'd9;
    localparam logic [3:0] S_H_CMP = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [tmhq_pkg::CountBits-1:0] FullCount =
        tmhq_pkg::CountBits'(tmhq_pkg::QueueDepth);
    localparam logic [tmhq_pkg::CountBits-1:0] One = tmhq_pkg::CountBits'(1);

    logic [3:0]                        r_state, n_state;
    logic [tmhq_pkg::CountBits-1:0]    r_count, n_count;
    logic [tmhq_pkg::CountBits-1:0]    r_idx, n_idx;
    logic [2:0]                        r_status, n_status;
    logic [tmhq_pkg::IdBits-1:0]       r_oid, n_oid;
    logic [tmhq_pkg::TimeBits-1:0]     r_next, n_next;
    logic [1:0]                        r_req;
    tmhq_pkg::t_entry                  r_new;
    logic [tmhq_pkg::TimeBits-1:0]     r_now;
    tmhq_pkg::t_store_ctl              w_ctl;
    tmhq_pkg::t_entry                  w_rdata;
    logic                              w_take;
    logic [tmhq_pkg::CountBits-1:0]    w_idx_m1, w_idx_p1;

    assign w_take   = i_valid && (r_state == S_IDLE);
    assign w_idx_m1 = r_idx - One;
    assign w_idx_p1 = r_idx + One;

    tmhq_store u_store (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        n_oid    = r_oid;
        n_next   = r_next;
        w_ctl.we    = 1'b0;
        w_ctl.waddr = r_idx[tmhq_pkg::AddrBits-1:0];
        w_ctl.wdata = r_new;
        w_ctl.raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_oid = '0;
                    case (i_req_type)
                        tmhq_pkg::REQ_ADD: begin
                            if (r_count == FullCount) begin
                                n_status = tmhq_pkg::ST_FULL;
                                n_state  = S_H_RD;
                            end else begin
                                n_status = tmhq_pkg::ST_ADDED;
                                n_idx    = r_count;
                                n_state  = S_A_RD;
                            end
                        end
                        tmhq_pkg::REQ_CANCEL: begin
                            n_status = tmhq_pkg::ST_MISS;
                            n_idx    = '0;
                            n_state  = S_C_RD;
                        end
                        tmhq_pkg::REQ_POP: begin
                            n_status = tmhq_pkg::ST_NONE;
                            n_state  = S_P_RD;
                        end
                        default: begin
                            n_status = tmhq_pkg::ST_NONE;
                            n_state  = S_H_RD;
                        end
                    endcase
                end
            end
            S_A_RD: begin
                if (r_idx == '0) begin
                    w_ctl.we = 1'b1;
                    n_count  = r_count + One;
                    n_state  = S_H_RD;
                end else begin
                    w_ctl.raddr = w_idx_m1[tmhq_pkg::AddrBits-1:0];
                    n_state     = S_A_CMP;
                end
            end
            S_A_CMP: begin
                w_ctl.we = 1'b1;
                if (w_rdata.expiry > r_new.expiry) begin
                    w_ctl.wdata = w_rdata;
                    n_idx       = w_idx_m1;
                    n_state     = S_A_RD;
                end else begin
                    n_count = r_count + One;
                    n_state = S_H_RD;
                end
            end
            S_C_RD: begin
                if (r_idx == r_count) begin
                    n_state = S_H_RD;
                end else begin
                    w_ctl.raddr = r_idx[tmhq_pkg::AddrBits-1:0];
                    n_state     = S_C_CMP;
                end
            end
            S_C_CMP: begin
                if (w_rdata.id == r_new.id) begin
                    n_status = tmhq_pkg::ST_CANCELLED;
                    n_oid    = w_rdata.id;
                    n_state  = S_S_RD;
                end else begin
                    n_idx   = w_idx_p1;
                    n_state = S_C_RD;
                end
            end
            S_S_RD: begin
                if (w_idx_p1 >= r_count) begin
                    n_count = r_count - One;
                    n_state = S_H_RD;
                end else begin
                    w_ctl.raddr = w_idx_p1[tmhq_pkg::AddrBits-1:0];
                    n_state     = S_S_CMP;
                end
            end
            S_S_CMP: begin
                w_ctl.we    = 1'b1;
                w_ctl.wdata = w_rdata;
                n_idx       = w_idx_p1;
                n_state     = S_S_RD;
            end
            S_P_RD: begin
                n_state = S_P_CMP;
            end
            S_P_CMP: begin
                if ((r_count != '0) && (w_rdata.expiry <= r_now)) begin
                    n_status = tmhq_pkg::ST_POPPED;
                    n_oid    = w_rdata.id;
                    n_idx    = '0;
                    n_state  = S_S_RD;
                end else begin
                    n_state = S_H_RD;
                end
            end
            S_H_RD: begin
                n_state = S_H_CMP;
            end
            S_H_CMP: begin
                n_next  = (r_count != '0) ? w_rdata.expiry : '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_oid    <= n_oid;
        r_next   <= n_next;
        if (w_take) begin
            r_req        <= i_req_type;
            r_new.expiry <= i_expire_time;
            r_new.id     <= i_task_id;
            r_now        <= i_now_time;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_status      = r_status;
    assign o_out_task_id = r_oid;
    assign o_next_valid  = (r_count != '0);
    assign o_next_expiry = r_next;
    assign o_entry_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCount)
        else $error("entry count beyond queue depth");
    a_out_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && r_status == tmhq_pkg::ST_ADDED) |-> (r_req == tmhq_pkg::REQ_ADD))
        else $error("added status without an add request");
    a_full_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("entry count changed at acceptance");
endmodule

>>> rtl/tmhq_store.sv
// Timer entry storage kept sorted by expiry, one write and one registered read per cycle.
module tmhq_store (
    input  logic                 i_clk,
    input  tmhq_pkg::t_store_ctl i_ctl,
    output tmhq_pkg::t_entry     o_rdata
);
    tmhq_pkg::t_entry r_mem [tmhq_pkg::QueueDepth];
    tmhq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_mem[i_ctl.raddr];
    end

    assign o_rdata = r_rdata;
endmodule
